// File: hw/rtl/assert_macros.svh
// Assertion helper macros used by the scanner top level.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: payload types, register
// indexes and fixed pattern geometry. No dependencies.
package wbps_pkg;

	localparam int PATTERN_CAP = 48;        // pattern positions the registers hold
	localparam int PATTERN_REGS = 6;        // 64-bit pattern registers
	localparam int PAT_REG_W = 64;
	localparam int MASK_W = 48;
	localparam int LEN_W = 6;
	localparam int OFF_W = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT5 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd7;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] match_offset;
	} out_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             len_ok;
	} pat_ctl_t;

endpackage

// File: hw/rtl/wbps_cfg.sv
// Configuration registers of the scanner and the pattern realigned by age.
// Depends on wbps_pkg.
module wbps_cfg import wbps_pkg::*; #(
	parameter int WIN = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_REG_W-1:0] cfg_data,
	output logic [7:0]           pat_al [WIN],
	output logic [WIN-1:0]       wild_al,
	output pat_ctl_t             ctl
);

	logic [PATTERN_CAP*8-1:0] pat_q;
	logic [MASK_W-1:0]        mask_q;
	logic [LEN_W-1:0]         len_q;
	logic [7:0]               pat_b [PATTERN_CAP];
	logic [LEN_W-1:0]         pos [WIN];
	logic [WIN-1:0]           active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			mask_q <= '0;
			len_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3, REG_PAT4, REG_PAT5: begin
					pat_q[cfg_index*PAT_REG_W +: PAT_REG_W] <= cfg_data;
				end
				REG_WILDCARD: begin
					mask_q <= cfg_data[MASK_W-1:0];
				end
				REG_LENGTH: begin
					len_q <= cfg_data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign ctl.len = len_q;
	assign ctl.len_ok = (len_q != '0) && (int'(len_q) <= WIN);

	// age a of the window lines up with pattern position len-1-a
	always_comb begin
		for (int k = 0; k < PATTERN_CAP; k++) begin
			pat_b[k] = pat_q[k*8 +: 8];
		end
		for (int a = 0; a < WIN; a++) begin
			pos[a] = len_q - LEN_W'(a) - LEN_W'(1);
			active[a] = ctl.len_ok && (a < int'(len_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wild_al <= '1;
			for (int a = 0; a < WIN; a++) begin
				pat_al[a] <= '0;
			end
		end else begin
			for (int a = 0; a < WIN; a++) begin
				pat_al[a] <= active[a] ? pat_b[pos[a]] : 8'h00;
				wild_al[a] <= !active[a] || mask_q[pos[a]];
			end
		end
	end

endmodule

// File: hw/rtl/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_cfg and assert_macros.svh.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one image byte per transfer,
//    last_byte marks the end of an image.
//  - out channel (out_valid/out_ready/out_data): at most one transfer per
//    image: found=1 with the start offset of the first match, or found=0
//    on the last byte when nothing matched.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    write only while no byte is in flight. A write may fall inside an
//    image and then applies to the bytes already held in the window.
// Throughput: one byte per cycle while the output is not stalled; every window
// position is compared in parallel in the single compare stage.
// A byte accepted into the compare stage is compared there, and its result
// (if any) loads the output register when that stage advances.
// Reset clears the scan state, the configuration and both stage valids.
// A stalled receiver holds the output register; the compare stage then
// holds its byte and in_ready drops until the result is taken.
`include "assert_macros.svh"

module wildcard_byte_pattern_scan import wbps_pkg::*; #(
	parameter int PATTERN_MAX = 48,
	parameter int OFFSET_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_REG_W-1:0] cfg_data
);

	// only the newest min(PATTERN_MAX, 48) bytes can ever be compared
	localparam int WIN = (PATTERN_MAX < PATTERN_CAP) ? PATTERN_MAX : PATTERN_CAP;

	logic [7:0]             pat_al [WIN];
	logic [WIN-1:0]         wild_al;
	pat_ctl_t               ctl;

	// input stage
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   adv;

	// scan state
	logic [7:0]             win_q [WIN];
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   reported_q;

	// compare stage
	logic [7:0]             win_nx [WIN];
	logic [OFFSET_BITS-1:0] seen_nx;
	logic [OFFSET_BITS-1:0] diff;
	logic [OFFSET_BITS+OFF_W-1:0] diff_ext;
	logic [WIN-1:0]         pos_ok;
	logic                   hit;
	logic                   produce;

	logic                   out_valid_q;
	out_t                   out_q;

	wbps_cfg #(
		.WIN(WIN)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pat_al(pat_al),
		.wild_al(wild_al),
		.ctl(ctl)
	);

	assign cfg_ready = 1'b1;

	// compare stage moves when the output register is free or draining
	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data.image_byte;
			last_s1 <= in_data.last_byte;
		end
	end

	// window after this byte; age 0 is the newest byte
	always_comb begin
		win_nx[0] = byte_s1;
		for (int a = 1; a < WIN; a++) begin
			win_nx[a] = win_q[a-1];
		end
		for (int a = 0; a < WIN; a++) begin
			pos_ok[a] = wild_al[a] || (win_nx[a] == pat_al[a]);
		end
	end

	// byte counter sticks at all ones
	assign seen_nx = (seen_q == '1) ? seen_q : seen_q + 1'b1;

	// a match needs a usable length and at least that many bytes seen
	assign hit = ctl.len_ok && (seen_nx >= OFFSET_BITS'(ctl.len)) && (&pos_ok);
	assign produce = !reported_q && (hit || last_s1);

	assign diff = seen_nx - OFFSET_BITS'(ctl.len);
	assign diff_ext = {{OFF_W{1'b0}}, diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			reported_q <= 1'b0;
			for (int a = 0; a < WIN; a++) begin
				win_q[a] <= '0;
			end
		end else if (adv) begin
			if (last_s1) begin
				// end of image: clear for the next scan
				seen_q <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				seen_q <= seen_nx;
				reported_q <= hit;
				for (int a = 0; a < WIN; a++) begin
					win_q[a] <= win_nx[a];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_q.found <= hit;
			out_q.match_offset <= hit ? diff_ext[OFF_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// not-found results carry a zero offset
	`ASSERT_IMP(a_notfound_zero, clk, arst_n, out_valid && !out_data.found, out_data.match_offset == '0)
	// after a match, further bytes of the same image leave the counter alone
	`ASSERT_NEXT(a_hold_after_match, clk, arst_n, adv && reported_q && !last_s1, $stable(seen_q) && reported_q)
	// the last byte always leaves a clean scan state
	`ASSERT_NEXT(a_clear_on_last, clk, arst_n, adv && last_s1, seen_q == '0 && !reported_q)

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for wildcard_byte_pattern_scan: directed and random image scans,
// each match report checked against a transaction-level predictor.
// Depends on wbps_pkg and the scanner RTL.
module testbench;
	import wbps_pkg::*;

	localparam int SCAN_DEPTH = 48;      // window depth the dut is built with
	localparam int RANDOM_BYTES = 750;   // rough size of the random part
	localparam int QUIET_TAIL = 120;     // last bytes run with no idling
	localparam int DRAIN_CYCLES = 4;     // compare stage plus output register, with margin
	localparam int LEN_MAX = (1 << LEN_W) - 1;

	typedef logic [7:0] byte_q_t[$];

	// Tracks the scan state of the block and holds the reports it owes.
	class report_board;
		logic [PAT_REG_W-1:0] pattern_regs [PATTERN_REGS];
		logic [MASK_W-1:0] wildcards;
		logic [LEN_W-1:0] pat_len;
		logic [7:0] window [SCAN_DEPTH];  // index 0 is the newest byte
		logic [OFF_W-1:0] seen;
		bit reported;
		out_t expected_reports [$];
		int errors;

		function new();
			foreach (pattern_regs[i]) pattern_regs[i] = '0;
			wildcards = '0;
			pat_len = '0;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (window[i]) window[i] = 8'h00;
			seen = '0;
			reported = 1'b0;
		endfunction

		function logic [7:0] pattern_at(int pos);
			return pattern_regs[(pos / 8) % PATTERN_REGS][(pos % 8) * 8 +: 8];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_REG_W-1:0] value);
			case (idx)
				REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3, REG_PAT4, REG_PAT5:
					pattern_regs[idx] = value;
				REG_WILDCARD: wildcards = value[MASK_W-1:0];
				REG_LENGTH: pat_len = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// Empty and overlong patterns never match, nor does a window with fewer bytes seen than the length.
		function bit window_hit();
			int len;
			len = int'(pat_len);
			if (len == 0 || len > PATTERN_CAP || len > SCAN_DEPTH || seen < len)
				return 1'b0;
			for (int j = 0; j < len; j++) begin
				if (wildcards[j])
					continue;
				if (window[len - 1 - j] !== pattern_at(j))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_byte(in_t item);
			out_t rep;
			if (!reported) begin
				for (int k = SCAN_DEPTH - 1; k > 0; k--)
					window[k] = window[k - 1];
				window[0] = item.image_byte;
				// saturating count; out of reach in a run this short
				if (seen != '1)
					seen++;
				if (window_hit()) begin
					rep.found = 1'b1;
					rep.match_offset = seen - pat_len;
					expected_reports = {expected_reports, rep};
					reported = 1'b1;
				end else if (item.last_byte) begin
					rep.found = 1'b0;
					rep.match_offset = '0;
					expected_reports = {expected_reports, rep};
				end
			end
			if (item.last_byte)
				clear_scan();
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_reports.size() == 0) begin
				$error("unexpected result: found=%0d match_offset=%0d",
					got.found, got.match_offset);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
			if (got.match_offset !== want.match_offset) begin
				$error("match_offset: expected %0d, actual %0d",
					want.match_offset, got.match_offset);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_REG_W-1:0] cfg_data;

	bit idling = 1'b1;   // random stalls on both channels while set
	int bytes_sent = 0;
	report_board board = new();

	wildcard_byte_pattern_scan #(
		.PATTERN_MAX(SCAN_DEPTH),
		.OFFSET_BITS(OFF_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Transfers are sampled right at the edge, before any nonblocking update
	// of this step lands, so they see the values the dut sees.
	// Results are checked before inputs are noted: a byte taken at this edge
	// cannot have its report taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			if (in_valid && in_ready)
				board.note_byte(in_data);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	// Receiver: stalls in random bursts while idling is on.
	// Each step gets at most one assignment to out_ready.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// One byte transfer. Valid stays high from one byte to the next unless a
	// gap is put in, so it is never lowered and raised in the same step.
	task automatic send_byte(input in_t item);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_seq(input byte_q_t seq, input bit close);
		in_t item;
		foreach (seq[i]) begin
			item.image_byte = seq[i];
			item.last_byte = close && (i == seq.size() - 1);
			send_byte(item);
		end
	endtask

	// Register write; the wait after cfg_valid drops keeps it from toggling twice in
	// one step across back-to-back writes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_REG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every owed report, then for a byte that owes none to leave the
	// compare stage, so the block is idle before registers change.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// New pattern setup. Lengths are mostly short so matches stay cheap;
	// empty, overlong and full-width patterns show up now and then.
	// Upper data bits of the length write are random, as are those of most mask writes.
	task automatic random_config();
		logic [PAT_REG_W-1:0] value;
		int len;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = 0;
		else if (pick == 1)
			len = $urandom_range(PATTERN_CAP + 1, LEN_MAX);
		else if (pick == 2)
			len = PATTERN_CAP;
		else if (pick < 5)
			len = $urandom_range(9, PATTERN_CAP - 1);
		else
			len = $urandom_range(1, 8);
		for (int r = 0; r < PATTERN_REGS; r++) begin
			pick = $urandom_range(0, 9);
			value = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
			write_reg(REG_PAT0 + CFG_IDX_W'(r), value);
		end
		pick = $urandom_range(0, 5);
		value = (pick == 0) ? '1 : (pick == 1) ? '0 :
			{$urandom, $urandom} & {$urandom, $urandom};
		write_reg(REG_WILDCARD, value);
		value = {$urandom, $urandom};
		value[LEN_W-1:0] = LEN_W'(len);
		write_reg(REG_LENGTH, value);
	endtask

	// Mostly the pattern planted between random bytes (random content on
	// wildcard positions), some near misses with one byte spoiled, some noise.
	task automatic send_random_image(input bit close);
		byte_q_t seq;
		int kind;
		int fill;
		int spoil;
		kind = $urandom_range(0, 9);
		fill = (int'(board.pat_len) > PATTERN_CAP) ? PATTERN_CAP : int'(board.pat_len);
		if (kind < 2) begin
			repeat ($urandom_range(1, 20)) seq = {seq, 8'($urandom)};
		end else begin
			repeat ($urandom_range(0, 10)) seq = {seq, 8'($urandom)};
			spoil = (kind < 4 && fill > 0) ? $urandom_range(0, fill - 1) : -1;
			for (int j = 0; j < fill; j++) begin
				if (board.wildcards[j])
					seq = {seq, 8'($urandom)};
				else if (j == spoil)
					seq = {seq, board.pattern_at(j) ^ 8'($urandom_range(1, 255))};
				else
					seq = {seq, board.pattern_at(j)};
			end
			repeat ($urandom_range(0, 4)) seq = {seq, 8'($urandom)};
		end
		if (seq.size() == 0)
			seq = {seq, 8'($urandom)};
		send_seq(seq, close);
	endtask

	initial begin
		int directed_count;
		int images;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PAT0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: empty pattern, so not found
		send_seq('{8'h00, 8'hFF, 8'h00}, 1'b1);
		drain();

		// pattern DE AD ?? EF; mask bits above the 48 positions are dropped
		write_reg(REG_PAT0, 64'h0123_4567_EF00_ADDE);
		write_reg(REG_PAT1, '1);
		write_reg(REG_PAT2, {$urandom, $urandom});
		write_reg(REG_PAT3, {$urandom, $urandom});
		write_reg(REG_PAT4, {$urandom, $urandom});
		write_reg(REG_PAT5, '0);
		write_reg(REG_WILDCARD, 64'hFFFF_0000_0000_0004);
		write_reg(REG_LENGTH, 64'd4);
		// match at offset 1, bytes after it ignored until the last one
		send_seq('{8'h11, 8'hDE, 8'hAD, 8'h55, 8'hEF, 8'h22, 8'h33}, 1'b1);
		// match completed by the last byte
		send_seq('{8'hDE, 8'hAD, 8'h00, 8'hEF}, 1'b1);
		// image shorter than the pattern
		send_seq('{8'hDE, 8'hAD}, 1'b1);
		drain();

		// overlong pattern never matches, even all wildcard
		write_reg(REG_WILDCARD, '1);
		write_reg(REG_LENGTH, 64'd49);
		send_seq('{8'hFF, 8'h00}, 1'b1);
		drain();

		// setup change mid image: AA BB becomes AA ?? over the bytes held
		write_reg(REG_PAT0, 64'h0000_0000_0000_BBAA);
		write_reg(REG_WILDCARD, '0);
		write_reg(REG_LENGTH, 64'd2);
		send_seq('{8'hAA}, 1'b0);
		drain();
		write_reg(REG_WILDCARD, 64'h2);
		send_seq('{8'hCC}, 1'b1);

		// random phases; an image may stay open across a setup change
		directed_count = bytes_sent;
		while (bytes_sent < directed_count + RANDOM_BYTES) begin
			if (bytes_sent >= directed_count + RANDOM_BYTES - QUIET_TAIL)
				idling = 1'b0;
			drain();
			random_config();
			images = $urandom_range(2, 6);
			for (int n = 0; n < images; n++)
				send_random_image(n < images - 1 || $urandom_range(0, 7) != 0);
		end
		send_random_image(1'b1);
		drain();

		if (board.errors == 0 && board.expected_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
